[rtl/sbb_pkg.sv]
// Shared types, constants and the five-tap average for the separable box blur.
// Has no dependencies; sbb_if, sbb_front, sbb_back and the top level import it.
`timescale 1ns / 1ps
`default_nettype none

package sbb_pkg;

  localparam int FRAME_WIDTH_W      = 12;
  localparam int FRAME_HEIGHT_W     = 13;
  localparam int CFG_DATA_W         = 13;
  localparam int CFG_INDEX_W        = 1;
  localparam int COL_OUT_W          = 11;
  localparam int ROW_OUT_W          = 12;
  localparam int COL_MAX_W          = 13;
  localparam int ROW_MAX_W          = 16;
  localparam int MIN_DIM            = 5;
  localparam int RESET_FRAME_WIDTH  = 640;
  localparam int RESET_FRAME_HEIGHT = 480;
  localparam int JOB_QUEUE_DEPTH    = 4;
  localparam int RECIP5             = 13108;
  localparam int RECIP5_SHIFT       = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic                      enable;
    logic [CFG_INDEX_W-1:0]    index;
    logic [CFG_DATA_W-1:0]     data;
  } cfg_write_t;

  // One accepted pixel that finishes one or three horizontal results.
  typedef struct packed {
    logic [COL_MAX_W-1:0] base;
    logic [ROW_MAX_W-1:0] row;
    pixel_t [2:0]         hval;
    logic                 three;
    logic                 has_rows;
    logic                 mid;
    logic                 last_row;
  } job_t;

  // Floor of the sum over five, done as a multiply by a scaled reciprocal.
  function automatic logic [7:0] div5_sum(input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] c, input logic [7:0] d,
                                          input logic [7:0] e);
    logic [10:0] s;
    logic [23:0] p;
    s = 11'(a) + 11'(b) + 11'(c) + 11'(d) + 11'(e);
    p = 24'(s) * 24'(RECIP5);
    return p[RECIP5_SHIFT +: 8];
  endfunction

  function automatic pixel_t avg5(input pixel_t a, input pixel_t b, input pixel_t c,
                                  input pixel_t d, input pixel_t e);
    pixel_t res;
    res.red   = div5_sum(a.red, b.red, c.red, d.red, e.red);
    res.green = div5_sum(a.green, b.green, c.green, d.green, e.green);
    res.blue  = div5_sum(a.blue, b.blue, c.blue, d.blue, e.blue);
    return res;
  endfunction

endpackage

`default_nettype wire

[rtl/sbb_if.sv]
// Stream interfaces for the pixel input channel and the result output channel.
// Depends on sbb_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface sbb_in_if;
  import sbb_pkg::*;
  logic       valid;
  logic       ready;
  logic       start_of_frame;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, start_of_frame, red_in, green_in, blue_in, input ready);
  modport sink (input valid, start_of_frame, red_in, green_in, blue_in, output ready);
endinterface

interface sbb_out_if;
  import sbb_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [COL_OUT_W-1:0] col_out;
  logic [ROW_OUT_W-1:0] row_out;
  logic [7:0]           red_out;
  logic [7:0]           green_out;
  logic [7:0]           blue_out;
  logic                 last_of_step;
  logic                 end_of_frame;

  modport source (output valid, col_out, row_out, red_out, green_out, blue_out,
                  last_of_step, end_of_frame, input ready);
  modport sink (input valid, col_out, row_out, red_out, green_out, blue_out,
                last_of_step, end_of_frame, output ready);
endinterface

`default_nettype wire

[rtl/sbb_ram.sv]
// Generic single-write, single-read RAM with a registered, read-first output.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module sbb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

[rtl/sbb_queue.sv]
// Short first-in first-out queue of jobs between the front and back parts.
// No dependencies beyond the width and depth parameters.
`timescale 1ns / 1ps
`default_nettype none

module sbb_queue #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push_valid,
  output      logic             push_ready,
  input  wire logic [WIDTH-1:0] push_data,
  output      logic             pop_valid,
  input  wire logic             pop_ready,
  output      logic [WIDTH-1:0] pop_data
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/sbb_front.sv]
// Front part: frame position, raw pixel window and the horizontal five-tap pass.
// Depends on sbb_pkg and sbb_in_if; emits one job per pixel that ends a column.
`timescale 1ns / 1ps
`default_nettype none

module sbb_front #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire sbb_pkg::cfg_write_t cfg,
  sbb_in_if.sink                  pixels,
  output      logic               job_valid,
  input  wire logic               job_ready,
  output      sbb_pkg::job_t      job
);
  import sbb_pkg::*;

  localparam int CB  = $clog2(MAX_WIDTH);
  localparam int RB  = $clog2(MAX_HEIGHT);
  localparam int WB  = $clog2(MAX_WIDTH + 1);
  localparam int HB  = $clog2(MAX_HEIGHT + 1);
  localparam int CXW = CB + 1;
  localparam int RXW = RB + 1;

  function automatic logic [WB-1:0] clamp_w(input logic [FRAME_WIDTH_W-1:0] v);
    if (v < FRAME_WIDTH_W'(MIN_DIM)) begin
      return WB'(MIN_DIM);
    end else if (32'(v) > MAX_WIDTH) begin
      return WB'(MAX_WIDTH);
    end
    return WB'(v);
  endfunction

  function automatic logic [HB-1:0] clamp_h(input logic [FRAME_HEIGHT_W-1:0] v);
    if (v < FRAME_HEIGHT_W'(MIN_DIM)) begin
      return HB'(MIN_DIM);
    end else if (32'(v) > MAX_HEIGHT) begin
      return HB'(MAX_HEIGHT);
    end
    return HB'(v);
  endfunction

  logic [WB-1:0]  width;
  logic [HB-1:0]  height;
  logic [CB-1:0]  col_count;
  logic [RB-1:0]  row_count;
  pixel_t         raw_window [4];

  logic           accept;
  pixel_t         px;
  logic [CB-1:0]  c0;
  logic [RB-1:0]  r0;
  logic           wrap_col;
  logic [CB-1:0]  x;
  logic [RXW-1:0] r1;
  logic [RB-1:0]  y;
  logic [CXW-1:0] x_next;
  logic [RXW-1:0] y_next;
  logic           end_row;
  logic           last_row;
  logic [CB-1:0]  col_count_next;
  logic [RB-1:0]  row_count_next;

  assign pixels.ready = job_ready;
  assign accept       = pixels.valid && job_ready;
  assign px           = pixel_t'{pixels.red_in, pixels.green_in, pixels.blue_in};

  always_comb begin
    c0       = pixels.start_of_frame ? '0 : col_count;
    r0       = pixels.start_of_frame ? '0 : row_count;
    wrap_col = CXW'(c0) >= CXW'(width);
    x        = wrap_col ? '0 : c0;
    r1       = wrap_col ? RXW'(r0) + RXW'(1) : RXW'(r0);
    y        = (r1 >= RXW'(height)) ? '0 : RB'(r1);
    x_next   = CXW'(x) + CXW'(1);
    y_next   = RXW'(y) + RXW'(1);
    end_row  = x_next >= CXW'(width);
    last_row = y_next >= RXW'(height);

    if (end_row) begin
      col_count_next = '0;
      row_count_next = last_row ? '0 : RB'(y_next);
    end else begin
      col_count_next = CB'(x_next);
      row_count_next = y;
    end

    job_valid    = pixels.valid && (x >= CB'(2));
    job.base     = COL_MAX_W'(CB'(x - CB'(2)));
    job.row      = ROW_MAX_W'(y);
    job.hval[0]  = (x >= CB'(4)) ?
                   avg5(raw_window[0], raw_window[1], raw_window[2], raw_window[3], px) :
                   raw_window[2];
    job.hval[1]  = raw_window[3];
    job.hval[2]  = px;
    job.three    = end_row;
    job.has_rows = y >= RB'(2);
    job.mid      = y >= RB'(4);
    job.last_row = last_row;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      width      <= clamp_w(FRAME_WIDTH_W'(RESET_FRAME_WIDTH));
      height     <= clamp_h(FRAME_HEIGHT_W'(RESET_FRAME_HEIGHT));
      col_count  <= '0;
      row_count  <= '0;
      for (int i = 0; i < 4; i++) begin
        raw_window[i] <= '0;
      end
    end else begin
      if (cfg.enable) begin
        unique case (cfg.index)
          REG_FRAME_WIDTH: begin
            width <= clamp_w(cfg.data[FRAME_WIDTH_W-1:0]);
          end
          REG_FRAME_HEIGHT: begin
            height <= clamp_h(cfg.data[FRAME_HEIGHT_W-1:0]);
          end
          default: begin
          end
        endcase
      end
      if (accept) begin
        col_count     <= col_count_next;
        row_count     <= row_count_next;
        raw_window[0] <= raw_window[1];
        raw_window[1] <= raw_window[2];
        raw_window[2] <= raw_window[3];
        raw_window[3] <= px;
      end
    end
  end

endmodule

`default_nettype wire

[rtl/sbb_back.sv]
// Back part: walks each job's rows and columns, keeps four lines of horizontal
// results in line RAMs and forms the vertical average. Depends on sbb_pkg,
// sbb_out_if and sbb_ram.
`timescale 1ns / 1ps
`default_nettype none

module sbb_back #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          job_valid,
  output      logic          job_pop,
  input  wire sbb_pkg::job_t job,
  sbb_out_if.source          results
);
  import sbb_pkg::*;

  localparam int CB = $clog2(MAX_WIDTH);
  localparam int RB = $clog2(MAX_HEIGHT);

  typedef enum logic [2:0] {
    MODE_MID  = 3'b001,
    MODE_BANK = 3'b010,
    MODE_HVAL = 3'b100
  } mode_t;

  typedef struct packed {
    mode_t         mode;
    logic [1:0]    bank;
    pixel_t        hval;
    logic [CB-1:0] col;
    logic [RB-1:0] row;
    logic          last;
    logic          eof;
  } issue_t;

  logic [1:0]  ri;
  logic [1:0]  ci;
  logic        s1_valid;
  issue_t      s1;
  issue_t      s1_next;
  logic        out_valid;
  logic [COL_OUT_W-1:0] out_col;
  logic [ROW_OUT_W-1:0] out_row;
  pixel_t      out_pix;
  logic        out_last;
  logic        out_eof;

  logic        adv;
  logic        issue;
  logic [1:0]  ri_last;
  logic [1:0]  ci_last;
  logic [RB-1:0] y;
  logic        wr_en;
  logic [1:0]  wr_bank;
  logic [23:0] rd [4];
  pixel_t      result;

  assign adv   = !out_valid || results.ready;
  assign issue = adv && job_valid;
  assign y     = RB'(job.row);

  always_comb begin
    ri_last = (job.has_rows && job.last_row) ? 2'd2 : 2'd0;
    ci_last = job.three ? 2'd2 : 2'd0;

    s1_next.col  = CB'(CB'(job.base) + CB'(ci));
    s1_next.last = (ri == ri_last) && (ci == ci_last);
    s1_next.eof  = job.last_row && job.three && (ri == 2'd2) && (ci == 2'd2);

    case (ci)
      2'd0:    s1_next.hval = job.hval[0];
      2'd1:    s1_next.hval = job.hval[1];
      default: s1_next.hval = job.hval[2];
    endcase

    case (ri)
      2'd0: begin
        s1_next.row  = RB'(y - RB'(2));
        s1_next.mode = job.mid ? MODE_MID : MODE_BANK;
        s1_next.bank = 2'(y - RB'(2));
      end
      2'd1: begin
        s1_next.row  = RB'(y - RB'(1));
        s1_next.mode = MODE_BANK;
        s1_next.bank = 2'(y - RB'(1));
      end
      default: begin
        s1_next.row  = y;
        s1_next.mode = MODE_HVAL;
        s1_next.bank = y[1:0];
      end
    endcase

    job_pop = issue && s1_next.last;
    wr_en   = issue && (ri == 2'd0);
    wr_bank = y[1:0];
  end

  // Line y&3 is written on the first row pass; the read of the oldest tap on the
  // same line and column in that cycle returns the previous contents.
  for (genvar b = 0; b < 4; b++) begin : g_line
    sbb_ram #(
      .WIDTH ($bits(pixel_t)),
      .DEPTH (MAX_WIDTH)
    ) u_line (
      .clk   (clk),
      .we    (wr_en && (wr_bank == 2'(b))),
      .waddr (s1_next.col),
      .wdata (s1_next.hval),
      .re    (adv),
      .raddr (s1_next.col),
      .rdata (rd[b])
    );
  end

  always_comb begin
    unique case (s1.mode)
      MODE_MID:  result = avg5(pixel_t'(rd[0]), pixel_t'(rd[1]), pixel_t'(rd[2]),
                               pixel_t'(rd[3]), s1.hval);
      MODE_BANK: result = pixel_t'(rd[s1.bank]);
      MODE_HVAL: result = s1.hval;
      default:   result = s1.hval;
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1       <= s1_next;
      out_col  <= COL_OUT_W'(s1.col);
      out_row  <= ROW_OUT_W'(s1.row);
      out_pix  <= result;
      out_last <= s1.last;
      out_eof  <= s1.eof;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ri        <= '0;
      ci        <= '0;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv) begin
        s1_valid  <= issue && job.has_rows;
        out_valid <= s1_valid;
      end
      if (issue) begin
        if (ci == ci_last) begin
          ci <= '0;
          ri <= (ri == ri_last) ? 2'd0 : ri + 2'd1;
        end else begin
          ci <= ci + 2'd1;
        end
      end
    end
  end

  assign results.valid        = out_valid;
  assign results.col_out      = out_col;
  assign results.row_out      = out_row;
  assign results.red_out      = out_pix.red;
  assign results.green_out    = out_pix.green;
  assign results.blue_out     = out_pix.blue;
  assign results.last_of_step = out_last;
  assign results.end_of_frame = out_eof;

endmodule

`default_nettype wire

[rtl/separable_box_blur_5x5_unit.sv]
// Top level of the separable 5x5 box blur: front part, job queue and back part.
// Depends on sbb_pkg, sbb_if, sbb_front, sbb_queue and sbb_back.
//
// Pixels arrive in raster order on the pixels channel, one word per handshake;
// start_of_frame on a word sets its position to column 0, row 0. Blurred pixels
// leave on the results channel, one word per output pixel, each carrying its
// column and row. Output pixel (x-2, y-2) leaves for input (x, y); the last
// pixel of a row also yields the last two columns, and pixels of the last row
// also yield the last two rows, so one input gives up to nine words.
// frame_width and frame_height are set through the write port.
// An input word is taken every cycle while the four-entry job queue has room.
// The back part issues one line-RAM access per output word, so it sustains one
// result per cycle while results.ready is high; a pixel that yields n words
// holds it until all n are issued, and a pixel of the first two rows writes
// the line RAMs only. The first result passes the job queue, register s1 and
// the output register before it is valid. Reset clears the position counters,
// the pixel window and all handshake state, and loads 640 by 480; the line
// RAMs are not cleared. While results.ready is low the output word holds, the
// back part stops, and input is taken until the queue fills.
`timescale 1ns / 1ps
`default_nettype none

module separable_box_blur_5x5_unit #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 4096
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            write_enable,
  input  wire logic [sbb_pkg::CFG_INDEX_W-1:0] write_index,
  input  wire logic [sbb_pkg::CFG_DATA_W-1:0]  write_data,
  sbb_in_if.sink                               pixels,
  sbb_out_if.source                            results
);
  import sbb_pkg::*;

  cfg_write_t cfg;
  job_t       front_job;
  job_t       back_job;
  logic       front_valid;
  logic       front_ready;
  logic       back_valid;
  logic       back_pop;

  assign cfg = cfg_write_t'{write_enable, write_index, write_data};

  sbb_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pixels    (pixels),
    .job_valid (front_valid),
    .job_ready (front_ready),
    .job       (front_job)
  );

  sbb_queue #(
    .WIDTH ($bits(job_t)),
    .DEPTH (JOB_QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_job),
    .pop_valid  (back_valid),
    .pop_ready  (back_pop),
    .pop_data   (back_job)
  );

  sbb_back #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (back_valid),
    .job_pop   (back_pop),
    .job       (back_job),
    .results   (results)
  );

endmodule

`default_nettype wire
